// File: design/alu16_pkg.sv
// Shared types and constants for the 16-bit ALU with iterative multiply/divide.
package alu16_pkg;

    localparam int DATA_W     = 16;
    localparam int UNIT_STEPS = 16;
    localparam int STEP_W     = $clog2(UNIT_STEPS);
    localparam int IN_W       = 40;
    localparam int OUT_W      = 40;

    localparam logic [3:0] SHIFT_MASK = 4'hF;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_OR  = 4'd2,
        OP_AND = 4'd3,
        OP_NOT = 4'd4,
        OP_XOR = 4'd5,
        OP_MUL = 4'd6,
        OP_DIV = 4'd7,
        OP_SLT = 4'd8,
        OP_SGT = 4'd9,
        OP_SEQ = 4'd10,
        OP_SLL = 4'd11,
        OP_SRL = 4'd12
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RUN,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic load_op;
        logic start_unit;
        logic step_unit;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic multi_cycle;
    } status_t;

endpackage

// File: design/alu16_ctrl.sv
// Controller: sequences accept, execute, multiply/divide iterations and result load.
module alu16_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  alu16_pkg::status_t status,
    output alu16_pkg::cmd_t    cmd
);

    alu16_pkg::state_t              state_reg;
    alu16_pkg::state_t              state_next;
    logic [alu16_pkg::STEP_W-1:0]   count_reg;
    logic [alu16_pkg::STEP_W-1:0]   count_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic                           out_free;
    logic                           last_step;

    assign out_free  = !out_valid_reg || m_ready;
    assign last_step = (count_reg == alu16_pkg::STEP_W'(alu16_pkg::UNIT_STEPS - 1));
    assign m_valid   = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= alu16_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            alu16_pkg::ST_IDLE:
            begin
                s_ready = 1'b1;
                if (s_valid)
                begin
                    cmd.load_op = 1'b1;
                    state_next  = alu16_pkg::ST_EXEC;
                end
            end
            alu16_pkg::ST_EXEC:
            begin
                if (status.multi_cycle)
                begin
                    cmd.start_unit = 1'b1;
                    count_next     = '0;
                    state_next     = alu16_pkg::ST_RUN;
                end
                else if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = alu16_pkg::ST_IDLE;
                end
            end
            alu16_pkg::ST_RUN:
            begin
                cmd.step_unit = 1'b1;
                count_next    = count_reg + 1'b1;
                if (last_step)
                begin
                    state_next = alu16_pkg::ST_FIN;
                end
            end
            alu16_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = alu16_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = alu16_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || m_ready))
        else $error("result beat overwritten before taken");

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (s_valid && s_ready) |=> (state_reg == alu16_pkg::ST_EXEC))
        else $error("accepted beat not executed next cycle");

    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == alu16_pkg::ST_RUN && last_step) |=> (state_reg == alu16_pkg::ST_FIN))
        else $error("iteration count not honored");
`endif

endmodule

// File: design/alu16_dp.sv
// Datapath: operand registers, shared shift-add/subtract unit, high register, result register.
module alu16_dp
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [alu16_pkg::IN_W-1:0]      in_data,
    input  alu16_pkg::cmd_t                 cmd,
    output alu16_pkg::status_t              status,
    output logic [alu16_pkg::OUT_W-1:0]     out_data
);

    localparam int W = alu16_pkg::DATA_W;

    alu16_pkg::op_t     act_reg;
    logic signed [W-1:0] a_reg;
    logic signed [W-1:0] b_reg;
    logic [W:0]          acc_reg;
    logic [W:0]          acc_next;
    logic [W-1:0]        q_reg;
    logic [W-1:0]        q_next;
    logic [W-1:0]        m_reg;
    logic [W-1:0]        high_reg;
    logic [W-1:0]        res_out_reg;
    logic [W-1:0]        high_out_reg;
    logic                ovf_out_reg;
    logic                zero_out_reg;
    logic                inval_out_reg;

    logic [W-1:0]        abs_a;
    logic [W-1:0]        abs_b;
    logic                is_mul;
    logic                b_zero;
    logic [W:0]          mul_sum;
    logic [W:0]          rem_sh;
    logic                rem_ge;
    logic [2*W-1:0]      prod_mag;
    logic [2*W-1:0]      prod;
    logic                neg;
    logic [W-1:0]        quot;
    logic [W-1:0]        rem;
    logic [W:0]          sum17;
    logic [W:0]          dif17;
    logic [3:0]          sh;
    logic [W-1:0]        res_c;
    logic                ovf_c;
    logic                inval_c;
    logic                high_we;
    logic [W-1:0]        high_c;

    assign abs_a  = a_reg[W-1] ? W'(~a_reg + 1'b1) : W'(a_reg);
    assign abs_b  = b_reg[W-1] ? W'(~b_reg + 1'b1) : W'(b_reg);
    assign is_mul = (act_reg == alu16_pkg::OP_MUL);
    assign b_zero = (b_reg == '0);
    assign neg    = a_reg[W-1] ^ b_reg[W-1];

    assign status.multi_cycle = is_mul || (act_reg == alu16_pkg::OP_DIV && !b_zero);

    // shift-add multiply step / restoring divide step
    assign mul_sum = q_reg[0] ? (acc_reg + {1'b0, m_reg}) : acc_reg;
    assign rem_sh  = {acc_reg[W-1:0], q_reg[W-1]};
    assign rem_ge  = (rem_sh >= {1'b0, m_reg});

    always_comb
    begin
        if (is_mul)
        begin
            acc_next = {1'b0, mul_sum[W:1]};
            q_next   = {mul_sum[0], q_reg[W-1:1]};
        end
        else
        begin
            acc_next = rem_ge ? (rem_sh - {1'b0, m_reg}) : rem_sh;
            q_next   = {q_reg[W-2:0], rem_ge};
        end
    end

    assign prod_mag = {acc_reg[W-1:0], q_reg};
    assign prod     = neg ? (~prod_mag + 1'b1) : prod_mag;
    assign quot     = neg ? W'(~q_reg + 1'b1) : q_reg;
    assign rem      = a_reg[W-1] ? W'(~acc_reg[W-1:0] + 1'b1) : acc_reg[W-1:0];

    assign sum17 = {a_reg[W-1], a_reg} + {b_reg[W-1], b_reg};
    assign dif17 = {a_reg[W-1], a_reg} - {b_reg[W-1], b_reg};
    assign sh    = b_reg[3:0] & alu16_pkg::SHIFT_MASK;

    always_comb
    begin
        res_c   = '0;
        ovf_c   = 1'b0;
        inval_c = 1'b0;
        high_we = 1'b0;
        high_c  = high_reg;
        unique case (act_reg)
            alu16_pkg::OP_ADD:
            begin
                res_c = sum17[W-1:0];
                ovf_c = sum17[W] ^ sum17[W-1];
            end
            alu16_pkg::OP_SUB:
            begin
                res_c = dif17[W-1:0];
                ovf_c = dif17[W] ^ dif17[W-1];
            end
            alu16_pkg::OP_OR:  res_c = a_reg | b_reg;
            alu16_pkg::OP_AND: res_c = a_reg & b_reg;
            alu16_pkg::OP_NOT: res_c = ~b_reg;
            alu16_pkg::OP_XOR: res_c = a_reg ^ b_reg;
            alu16_pkg::OP_MUL:
            begin
                res_c   = prod[W-1:0];
                high_we = 1'b1;
                high_c  = prod[2*W-1:W];
            end
            alu16_pkg::OP_DIV:
            begin
                if (b_zero)
                begin
                    ovf_c = 1'b1;
                end
                else
                begin
                    res_c   = quot;
                    high_we = 1'b1;
                    high_c  = rem;
                end
            end
            alu16_pkg::OP_SLT: res_c = {{(W-1){1'b0}}, (a_reg < b_reg)};
            alu16_pkg::OP_SGT: res_c = {{(W-1){1'b0}}, (a_reg > b_reg)};
            alu16_pkg::OP_SEQ: res_c = {{(W-1){1'b0}}, (a_reg == b_reg)};
            alu16_pkg::OP_SLL: res_c = W'(a_reg) << sh;
            alu16_pkg::OP_SRL: res_c = W'(a_reg) >> sh;
            default:
            begin
                inval_c = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_reg <= '0;
        end
        else if (cmd.load_out && high_we)
        begin
            high_reg <= high_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_op)
        begin
            act_reg <= alu16_pkg::op_t'(in_data[3:0]);
            a_reg   <= in_data[19:4];
            b_reg   <= in_data[35:20];
        end
        if (cmd.start_unit)
        begin
            acc_reg <= '0;
            q_reg   <= is_mul ? abs_b : abs_a;
            m_reg   <= is_mul ? abs_a : abs_b;
        end
        else if (cmd.step_unit)
        begin
            acc_reg <= acc_next;
            q_reg   <= q_next;
        end
        if (cmd.load_out)
        begin
            res_out_reg   <= res_c;
            high_out_reg  <= high_c;
            ovf_out_reg   <= ovf_c;
            zero_out_reg  <= (res_c == '0);
            inval_out_reg <= inval_c;
        end
    end

    assign out_data = {5'd0, inval_out_reg, zero_out_reg, ovf_out_reg, high_out_reg, res_out_reg};

`ifndef SYNTHESIS
    a_high_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.load_out |=> $stable(high_reg))
        else $error("high register changed without a result load");
`endif

endmodule

// File: design/alu16_with_mul_div.sv
// Top level of the 16-bit signed ALU with iterative multiply and divide.
// One beat at a time: an accepted beat is executed in the next cycle, where add, sub, logic,
// compare, shift, invalid codes and divide by zero load their result. Multiply and divide with
// a nonzero divisor run on one shared shift-add/shift-subtract unit, one bit per cycle over 16
// bits, through the states EXEC, RUN and FIN, and load their result in FIN. A result load waits
// while the output register still holds an untaken beat. A new beat is accepted as soon as the
// controller is idle, even while the previous result waits in the output register. Multiply
// leaves the upper product half, divide the remainder, in the high register; every result beat
// reports the high register's value after its operation.
module alu16_with_mul_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // action[3:0], operand_a[19:4], operand_b[35:20], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // result[15:0], high_word[31:16], overflow[32],
                                        // zero[33], invalid_op[34], zero pad
);

    alu16_pkg::cmd_t    cmd;
    alu16_pkg::status_t status;

    alu16_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .status  (status),
        .cmd     (cmd)
    );

    alu16_dp u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (s_axis_tdata),
        .cmd      (cmd),
        .status   (status),
        .out_data (m_axis_tdata)
    );

endmodule
